/* hw/rtl/box_mean_filter_core_defines.svh */
// Assertion macros for the box mean filter checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BOX_MEAN_FILTER_CORE_DEFINES_SVH
`define BOX_MEAN_FILTER_CORE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define BMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("box mean filter check failed");

// Checked at every clock edge, reset included.
`define BMF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("box mean filter check failed");

`endif

/* hw/rtl/bmf_pkg.sv */
// Shared types and constants for the box mean filter.
// No dependencies; every other file of the block but the macro header uses it.
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

  localparam int MAX_PADDED_WIDTH_DEF = 1024;
  localparam int PIXEL_BITS_DEF       = 16;

  localparam int IO_PIX_BITS   = 16;
  localparam int IMG_W_BITS    = 10;
  localparam int IMG_H_BITS    = 13;
  localparam int RADIUS_BITS   = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam int MAX_HEIGHT    = 4096;

  // Front-to-back queue.
  localparam int QUEUE_DEPTH    = 8;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IMG_W_BITS-1:0]  image_width;
    logic [IMG_H_BITS-1:0]  image_height;
    logic [RADIUS_BITS-1:0] window_radius;
  } cfg_t;

  // Per-result side info carried with the window sum.
  typedef struct packed {
    logic r5;
    logic row_end;
    logic frame_end;
  } win_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/bmf_pixel_if.sv */
// Input pixel channel: valid/ready handshake plus one pixel per beat.
// Width taken from bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmf_pixel_if;
  logic                             valid;
  logic                             ready;
  logic [bmf_pkg::IO_PIX_BITS-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bmf_mean_if.sv */
// Result channel: valid/ready handshake plus mean and position flags per beat.
// Width taken from bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmf_mean_if;
  logic                             valid;
  logic                             ready;
  logic [bmf_pkg::IO_PIX_BITS-1:0]  mean;
  logic                             row_end;
  logic                             frame_end;

  modport source (output valid, output mean, output row_end, output frame_end, input ready);
  modport sink   (input valid, input mean, input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bmf_front.sv */
// Front end: position counters, line store, window column sums, window sum.
// Uses bmf_pkg and bmf_pixel_if; pushes one entry per interior pixel.
`timescale 1ns / 1ps
`default_nettype none

module bmf_front #(
  parameter int MAX_PADDED_WIDTH = bmf_pkg::MAX_PADDED_WIDTH_DEF,
  parameter int PIXEL_BITS       = bmf_pkg::PIXEL_BITS_DEF,
  parameter int SUM_W            = 21
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire bmf_pkg::cfg_t                         cfg_i,
  bmf_pixel_if.sink                                  pix_i,
  input  wire logic [bmf_pkg::QUEUE_CNT_BITS-1:0]    q_cnt_i,
  output logic                                       push_o,
  output logic [SUM_W-1:0]                           sum_o,
  output bmf_pkg::win_flags_t                        flags_o
);

  localparam int PIX_W = (PIXEL_BITS < bmf_pkg::IO_PIX_BITS) ? PIXEL_BITS
                                                              : bmf_pkg::IO_PIX_BITS;
  localparam int AW    = $clog2(MAX_PADDED_WIDTH);
  localparam int PWW   = $clog2(MAX_PADDED_WIDTH + 1);
  localparam int EW    = ((PWW > bmf_pkg::IMG_W_BITS) ? PWW : bmf_pkg::IMG_W_BITS) + 1;
  localparam int HW    = bmf_pkg::IMG_H_BITS + 1;
  localparam int CS_W  = PIX_W + 3;
  localparam int CW    = bmf_pkg::QUEUE_CNT_BITS + 1;
  localparam int ROUND3 = 4;
  localparam int ROUND5 = 12;

  typedef logic [3:0][PIX_W-1:0] line_row_t;

  // ---- effective geometry ----
  logic           r5;
  logic [2:0]     two_r;
  logic [EW-1:0]  w_ext, w_lim, w_eff, pw, col_ext;
  logic [HW-1:0]  h_ext, h_eff, ph, row_ext;
  logic           last_col, last_row, emit;
  logic           acc;
  logic [AW-1:0]  addr;

  logic [bmf_pkg::IMG_W_BITS-1:0] col_q;
  logic [bmf_pkg::IMG_H_BITS-1:0] row_q;

  // stage B
  logic                b_vld_q, b_emit_q;
  bmf_pkg::win_flags_t b_flags_q;
  logic [AW-1:0]       b_addr_q;
  logic [PIX_W-1:0]    b_px_q;
  line_row_t           rd_q;
  line_row_t           wr_row;
  logic [CS_W-1:0]     s3, s5;

  line_row_t           line_mem_q [MAX_PADDED_WIDTH];

  // stage C
  logic                c_vld_q, c_emit_q;
  bmf_pkg::win_flags_t c_flags_q;
  logic [CS_W-1:0]     cs3_q [3];
  logic [CS_W-1:0]     cs5_q [5];
  logic [SUM_W-1:0]    win3, win5;

  always_comb begin
    r5    = cfg_i.window_radius[1];
    two_r = r5 ? 3'd4 : 3'd2;

    w_ext = EW'(cfg_i.image_width);
    w_lim = EW'(MAX_PADDED_WIDTH) - EW'(two_r);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > w_lim) begin
      w_eff = w_lim;
    end else begin
      w_eff = w_ext;
    end
    pw = w_eff + EW'(two_r);

    h_ext = HW'(cfg_i.image_height);
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HW'(bmf_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(bmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    ph = h_eff + HW'(two_r);

    col_ext  = EW'(col_q);
    row_ext  = HW'(row_q);
    last_col = (col_ext + EW'(1)) >= pw;
    last_row = (row_ext + HW'(1)) >= ph;
    emit     = (col_ext < pw) && (row_ext < ph) &&
               (col_ext >= EW'(two_r)) && (row_ext >= HW'(two_r));
  end

  // Column count always stays below the padded width, hence below the store depth.
  assign addr = AW'(col_q);

  // Room for everything already in flight plus this beat.
  assign pix_i.ready = (CW'(q_cnt_i) + CW'(b_vld_q) + CW'(c_vld_q)) <
                       CW'(bmf_pkg::QUEUE_DEPTH);
  assign acc = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      b_vld_q <= acc;
      c_vld_q <= b_vld_q;
      if (acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // Stage A -> B payload, line store read.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_addr_q            <= addr;
      b_px_q              <= pix_i.pixel[PIX_W-1:0];
      b_emit_q            <= emit;
      b_flags_q.r5        <= r5;
      b_flags_q.row_end   <= last_col;
      b_flags_q.frame_end <= last_col && last_row;
      rd_q                <= line_mem_q[addr];
    end
    if (b_vld_q) begin
      line_mem_q[b_addr_q] <= wr_row;
    end
  end

  // Every line moves one row down; the new pixel enters line 0.
  assign wr_row = {rd_q[2], rd_q[1], rd_q[0], b_px_q};
  assign s3 = CS_W'(b_px_q) + CS_W'(rd_q[0]) + CS_W'(rd_q[1]);
  assign s5 = s3 + CS_W'(rd_q[2]) + CS_W'(rd_q[3]);

  // Stage B -> C: column sums shift in, newest at the highest index.
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      cs3_q[0]  <= cs3_q[1];
      cs3_q[1]  <= cs3_q[2];
      cs3_q[2]  <= s3;
      cs5_q[0]  <= cs5_q[1];
      cs5_q[1]  <= cs5_q[2];
      cs5_q[2]  <= cs5_q[3];
      cs5_q[3]  <= cs5_q[4];
      cs5_q[4]  <= s5;
      c_emit_q  <= b_emit_q;
      c_flags_q <= b_flags_q;
    end
  end

  assign win3 = SUM_W'(cs3_q[0]) + SUM_W'(cs3_q[1]) + SUM_W'(cs3_q[2]) + SUM_W'(ROUND3);
  assign win5 = SUM_W'(cs5_q[0]) + SUM_W'(cs5_q[1]) + SUM_W'(cs5_q[2]) +
                SUM_W'(cs5_q[3]) + SUM_W'(cs5_q[4]) + SUM_W'(ROUND5);

  assign push_o  = c_vld_q && c_emit_q;
  assign sum_o   = c_flags_q.r5 ? win5 : win3;
  assign flags_o = c_flags_q;

endmodule

`default_nettype wire

/* hw/rtl/bmf_fifo.sv */
// Short queue between front and back of the box mean filter.
// Depth from bmf_pkg; register storage with one read pointer.
`timescale 1ns / 1ps
`default_nettype none

module bmf_fifo #(
  parameter int WIDTH = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  input  wire logic [WIDTH-1:0]                   data_i,
  input  wire logic                               pop_i,
  output logic                                    valid_o,
  output logic [WIDTH-1:0]                        data_o,
  output logic [bmf_pkg::QUEUE_CNT_BITS-1:0]      cnt_o
);

  logic [WIDTH-1:0]                     slot_q [bmf_pkg::QUEUE_DEPTH];
  logic [bmf_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [bmf_pkg::QUEUE_CNT_BITS-1:0]   cnt_q;
  logic                                 do_pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign cnt_o   = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + bmf_pkg::QUEUE_CNT_BITS'(push_i)
                     - bmf_pkg::QUEUE_CNT_BITS'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bmf_back.sv */
// Back end: divide the rounded window sum by 9 or 25 and hold the result beat.
// Uses bmf_pkg and bmf_mean_if; reciprocal multiply, then shift.
`timescale 1ns / 1ps
`default_nettype none

module bmf_back #(
  parameter int SUM_W      = 21
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  wire logic [SUM_W-1:0]       q_sum_i,
  input  wire bmf_pkg::win_flags_t    q_flags_i,
  output logic                        q_pop_o,
  bmf_mean_if.source                  res_o
);

  // Exact floor division for any sum below 2**SUM_W:
  // m = ceil(2**(SUM_W+l)/d) with 2**l >= d.
  localparam int K9  = SUM_W + 4;
  localparam int K25 = SUM_W + 5;
  localparam int MW  = SUM_W + 1;
  localparam longint unsigned M9  = ((64'd1 << K9) + 64'd8) / 64'd9;
  localparam longint unsigned M25 = ((64'd1 << K25) + 64'd24) / 64'd25;
  localparam int PRW = SUM_W + MW;

  logic                 out_en, mul_en;
  logic                 m_vld_q, o_vld_q;
  logic [PRW-1:0]       m_prod_q;
  logic [MW-1:0]        recip;
  bmf_pkg::win_flags_t  m_flags_q, o_flags_q;
  logic [bmf_pkg::IO_PIX_BITS-1:0] o_mean_q;

  assign out_en  = !o_vld_q || res_o.ready;
  assign mul_en  = !m_vld_q || out_en;
  assign q_pop_o = q_valid_i && mul_en;
  assign recip   = q_flags_i.r5 ? MW'(M25) : MW'(M9);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (mul_en) begin
        m_vld_q <= q_valid_i;
      end
      if (out_en) begin
        o_vld_q <= m_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      m_prod_q  <= PRW'(q_sum_i) * PRW'(recip);
      m_flags_q <= q_flags_i;
    end
    if (out_en) begin
      o_mean_q  <= m_flags_q.r5 ? bmf_pkg::IO_PIX_BITS'(m_prod_q >> K25)
                                : bmf_pkg::IO_PIX_BITS'(m_prod_q >> K9);
      o_flags_q <= m_flags_q;
    end
  end

  assign res_o.valid     = o_vld_q;
  assign res_o.mean      = o_mean_q;
  assign res_o.row_end   = o_flags_q.row_end;
  assign res_o.frame_end = o_flags_q.frame_end;

endmodule

`default_nettype wire

/* hw/rtl/box_mean_filter_core.sv */
// Top level of the streaming 3x3 / 5x5 box mean filter.
// Uses bmf_pkg, bmf_pixel_if, bmf_mean_if, bmf_front, bmf_fifo, bmf_back.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake            payload
//  pix_i     in   valid / ready        pixel[15:0]
//  res_o     out  valid / ready        mean[15:0], row_end, frame_end
//  cfg       in   cfg_we_i (no wait)   cfg_idx_i[1:0], cfg_data_i[12:0]
//
//  One pixel beat per clock is taken whenever the front has room; one mean
//  beat per clock leaves while res_o.ready stays high.
//  A mean passes stages B and C, the queue, m_prod_q and o_mean_q; one line
//  store read and one write every cycle let pixel beats come back to back.
//  Reset clears counters, config (width 8, height 8, radius 1) and valids;
//  the line store needs no clearing pass.
//  A stall on res_o fills the back end and the 8-entry queue; pix_i.ready
//  drops once queued plus in-flight front beats reach 8.

module box_mean_filter_core #(
  parameter int MAX_PADDED_WIDTH = bmf_pkg::MAX_PADDED_WIDTH_DEF,
  parameter int PIXEL_BITS       = bmf_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bmf_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [bmf_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  bmf_pixel_if.sink                                pix_i,
  bmf_mean_if.source                               res_o
);

  localparam int PIX_W  = (PIXEL_BITS < bmf_pkg::IO_PIX_BITS) ? PIXEL_BITS
                                                               : bmf_pkg::IO_PIX_BITS;
  // 25 pixels plus the rounding offset stay below 2**(PIX_W+5).
  localparam int SUM_W  = PIX_W + 5;
  localparam int FLAG_W = $bits(bmf_pkg::win_flags_t);
  localparam int ENTRY_W = SUM_W + FLAG_W;

  bmf_pkg::cfg_t cfg_q;

  logic                                 push;
  logic [SUM_W-1:0]                     push_sum;
  bmf_pkg::win_flags_t                  push_flags;
  logic                                 q_valid, q_pop;
  logic [ENTRY_W-1:0]                   q_data;
  logic [bmf_pkg::QUEUE_CNT_BITS-1:0]   q_cnt;
  bmf_pkg::win_flags_t                  q_flags;

  // Config writes take effect on the next pixel; index 3 is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= bmf_pkg::IMG_W_BITS'(8);
      cfg_q.image_height  <= bmf_pkg::IMG_H_BITS'(8);
      cfg_q.window_radius <= bmf_pkg::RADIUS_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmf_pkg::CFG_IMAGE_WIDTH:
          cfg_q.image_width <= cfg_data_i[bmf_pkg::IMG_W_BITS-1:0];
        bmf_pkg::CFG_IMAGE_HEIGHT:
          cfg_q.image_height <= cfg_data_i[bmf_pkg::IMG_H_BITS-1:0];
        bmf_pkg::CFG_WINDOW_RADIUS:
          cfg_q.window_radius <= cfg_data_i[bmf_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front: counters, line store, column and window sums.
  bmf_front #(
    .MAX_PADDED_WIDTH (MAX_PADDED_WIDTH),
    .PIXEL_BITS       (PIXEL_BITS),
    .SUM_W            (SUM_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .pix_i   (pix_i),
    .q_cnt_i (q_cnt),
    .push_o  (push),
    .sum_o   (push_sum),
    .flags_o (push_flags)
  );

  // Queue decouples a stalled result port from the pixel side.
  bmf_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_sum, push_flags}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .cnt_o   (q_cnt)
  );

  assign q_flags = q_data[FLAG_W-1:0];

  // Back: reciprocal divide and result register.
  bmf_back #(
    .SUM_W      (SUM_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_sum_i   (q_data[ENTRY_W-1:FLAG_W]),
    .q_flags_i (q_flags),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/bmf_checker.sv */
// Port-level checks for box_mean_filter_core, attached by bind.
// Uses the macros of box_mean_filter_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "box_mean_filter_core_defines.svh"

module bmf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [bmf_pkg::IO_PIX_BITS-1:0]   out_mean_i,
  input wire logic                              out_row_end_i,
  input wire logic                              out_frame_end_i
);

  // A stalled result beat holds its valid, mean and frame end.
  `BMF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_mean_i) && $stable(out_frame_end_i))

  // Frame end only ever comes on a row end.
  `BMF_ASSERT(a_frame_on_row, out_valid_i |-> (!out_frame_end_i || out_row_end_i))

  // Room in the queue never shrinks unless a pixel beat was taken.
  `BMF_ASSERT(a_ready_keeps, in_ready_i && !in_valid_i |=> in_ready_i)

  // Pipeline is empty after reset: no result just after reset is released.
  `BMF_ASSERT_ALWAYS(a_quiet_after_reset, $rose(rst_ni) |-> !out_valid_i ##1 !out_valid_i ##1 !out_valid_i)

endmodule

bind box_mean_filter_core bmf_checker u_bmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (pix_i.valid),
  .in_ready_i      (pix_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_mean_i      (res_o.mean),
  .out_row_end_i   (res_o.row_end),
  .out_frame_end_i (res_o.frame_end)
);

`default_nettype wire

/* sim/box_mean_filter_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for box_mean_filter_core: padded pixel frames in, box means out.
// Depends on bmf_pkg, bmf_pixel_if, bmf_mean_if and the core RTL.

module box_mean_filter_core_tb;

  localparam int LINE_SLOTS   = bmf_pkg::MAX_PADDED_WIDTH_DEF;
  localparam int SETTLE_CYC   = 8;     // settle time after a drain, with margin past the core pipeline
  localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either channel
  localparam int RANDOM_ITEMS = 1560;

  typedef struct packed {
    logic [bmf_pkg::IO_PIX_BITS-1:0] mean;
    logic                            row_end;
    logic                            frame_end;
  } mean_beat_t;

  typedef enum bit {ROW_CFG, ROW_PIX} row_kind_e;

  // One directed row: a register write, or a pixel sent `count` times.
  typedef struct {
    row_kind_e                       kind;
    bmf_pkg::cfg_idx_e               idx;
    int                              value;
    logic [bmf_pkg::IO_PIX_BITS-1:0] pixel;
    int                              count;
    bit                              typed;
    mean_beat_t                      beat;
  } stim_row_t;

  // Smallest frames: 1x1 interior gives one result on the last padded pixel.
  stim_row_t directed_rows [13] = '{
    '{ROW_CFG, bmf_pkg::CFG_IMAGE_WIDTH,   1, 16'h0000, 1, 1'b0, '0},
    '{ROW_CFG, bmf_pkg::CFG_IMAGE_HEIGHT,  1, 16'h0000, 1, 1'b0, '0},
    '{ROW_CFG, bmf_pkg::CFG_WINDOW_RADIUS, 1, 16'h0000, 1, 1'b0, '0},
    '{ROW_PIX, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'hFFFF, 8, 1'b0, '0},
    // all-max window: mean stays at full scale, ends row and frame
    '{ROW_PIX, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'hFFFF, 1, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
    // zero width, zero height and zero radius all act as one
    '{ROW_CFG, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'h0000, 1, 1'b0, '0},
    '{ROW_CFG, bmf_pkg::CFG_IMAGE_HEIGHT,  0, 16'h0000, 1, 1'b0, '0},
    '{ROW_CFG, bmf_pkg::CFG_WINDOW_RADIUS, 0, 16'h0000, 1, 1'b0, '0},
    '{ROW_PIX, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'h0000, 8, 1'b0, '0},
    '{ROW_PIX, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'h0000, 1, 1'b1, '{16'h0000, 1'b1, 1'b1}},
    // two interior columns: first result is mid-row
    '{ROW_CFG, bmf_pkg::CFG_IMAGE_WIDTH,   2, 16'h0000, 1, 1'b0, '0},
    '{ROW_PIX, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'hAAAA, 6, 1'b0, '0},
    '{ROW_PIX, bmf_pkg::CFG_IMAGE_WIDTH,   0, 16'h5555, 6, 1'b0, '0}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [bmf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [bmf_pkg::CFG_DATA_BITS-1:0] cfg_data_i;

  bmf_pixel_if pix_if ();
  bmf_mean_if  mean_if ();

  box_mean_filter_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (mean_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Filter image kept by the bench: line buffers, 5x5 window, frame position, registers.
  logic [bmf_pkg::IO_PIX_BITS-1:0] lines [4][LINE_SLOTS];
  logic [bmf_pkg::IO_PIX_BITS-1:0] win [25];
  int unsigned            col_pos    = 0;
  int unsigned            row_pos    = 0;
  int unsigned            reg_width  = 8;
  int unsigned            reg_height = 8;
  int unsigned            reg_radius = 1;

  mean_beat_t  means_due [$];
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  // Advance the filter image by one pixel; hit is set when the pixel completes
  // the window of an interior pixel.
  task automatic filter_pixel(input logic [bmf_pkg::IO_PIX_BITS-1:0] px, output bit hit,
                              output mean_beat_t beat);
    int unsigned                     rad, w, h, pw, ph, c, i, j, taps, acc;
    logic [bmf_pkg::IO_PIX_BITS-1:0] column [5];
    bit                              at_row_end, at_frame_end;
    rad = (reg_radius <= 1) ? 1 : 2;
    w = (reg_width < 1) ? 1 : reg_width;
    if (w > LINE_SLOTS - 2 * rad) w = LINE_SLOTS - 2 * rad;
    h = (reg_height < 1) ? 1 : reg_height;
    if (h > bmf_pkg::MAX_HEIGHT) h = bmf_pkg::MAX_HEIGHT;
    pw = w + 2 * rad;
    ph = h + 2 * rad;
    c = col_pos % LINE_SLOTS;

    // New window column, oldest row on top, this pixel at the bottom.
    column[0] = lines[3][c];
    column[1] = lines[2][c];
    column[2] = lines[1][c];
    column[3] = lines[0][c];
    column[4] = px;
    lines[3][c] = column[1];
    lines[2][c] = column[2];
    lines[1][c] = column[3];
    lines[0][c] = px;
    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 4; j++) win[i*5+j] = win[i*5+j+1];
      win[i*5+4] = column[i];
    end

    at_row_end   = (col_pos + 1 >= pw);
    at_frame_end = at_row_end && (row_pos + 1 >= ph);
    hit = (col_pos < pw) && (row_pos < ph) && (col_pos >= 2 * rad) && (row_pos >= 2 * rad);
    beat = '0;
    if (hit) begin
      acc = 0;
      for (i = 4 - 2 * rad; i < 5; i++)
        for (j = 4 - 2 * rad; j < 5; j++) acc += win[i*5+j];
      taps = (2 * rad + 1) * (2 * rad + 1);
      beat.mean      = bmf_pkg::IO_PIX_BITS'((acc + taps / 2) / taps);
      beat.row_end   = at_row_end;
      beat.frame_end = at_frame_end;
    end

    if (at_row_end) begin
      col_pos = 0;
      row_pos = at_frame_end ? 0 : ((row_pos + 1) & ((1 << bmf_pkg::IMG_H_BITS) - 1));
    end else begin
      col_pos = (col_pos + 1) & ((1 << bmf_pkg::IMG_W_BITS) - 1);
    end
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  // Hold the pixel channel until every pending mean has come back.
  task automatic drain(input int settle);
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (means_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register writes only land on an idle core, between frames.
  task automatic write_reg(input bmf_pkg::cfg_idx_e idx, input int value);
    drain(SETTLE_CYC);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[bmf_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bmf_pkg::CFG_IMAGE_WIDTH:   reg_width  = value & ((1 << bmf_pkg::IMG_W_BITS) - 1);
      bmf_pkg::CFG_IMAGE_HEIGHT:  reg_height = value & ((1 << bmf_pkg::IMG_H_BITS) - 1);
      bmf_pkg::CFG_WINDOW_RADIUS: reg_radius = value & ((1 << bmf_pkg::RADIUS_BITS) - 1);
      default: ;
    endcase
  endtask

  // One pixel beat; typed_beat replaces the computed mean on directed rows.
  task automatic feed_pixel(input logic [bmf_pkg::IO_PIX_BITS-1:0] px, input bit typed,
                            input mean_beat_t typed_beat);
    bit         hit;
    mean_beat_t beat;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    filter_pixel(px, hit, beat);
    if (hit) means_due.push_back(typed ? typed_beat : beat);
  endtask

  // Stream one complete padded frame of random pixels; frame end is when the
  // position wraps back to the origin.
  task automatic stream_frame(input bit hold_mid, inout int unsigned fed);
    int unsigned                     n;
    bit                              held;
    logic [bmf_pkg::IO_PIX_BITS-1:0] px;
    n = 0;
    held = 1'b0;
    do begin
      case ($urandom_range(7))
        0:       px = '0;
        1:       px = '1;
        default: px = bmf_pkg::IO_PIX_BITS'($urandom_range(65535));
      endcase
      // mid-frame pause: stop sending until the core has emptied out
      if (hold_mid && !held && means_due.size() != 0) begin
        drain(0);
        held = 1'b1;
      end
      feed_pixel(px, 1'b0, '0);
      n++;
    end while (col_pos != 0 || row_pos != 0);
    fed += n;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin : result_check
    mean_beat_t due;
    if (rst_ni && mean_if.valid && mean_if.ready) begin
      if (means_due.size() == 0) begin
        $error("mean beat with nothing expected: mean %0d", mean_if.mean);
        mismatches++;
      end else begin
        due = means_due.pop_front();
        if (mean_if.mean !== due.mean) begin
          $error("mean: expected %0d, got %0d", due.mean, mean_if.mean);
          mismatches++;
        end
        if (mean_if.row_end !== due.row_end) begin
          $error("row_end: expected %0d, got %0d", due.row_end, mean_if.row_end);
          mismatches++;
        end
        if (mean_if.frame_end !== due.frame_end) begin
          $error("frame_end: expected %0d, got %0d", due.frame_end, mean_if.frame_end);
          mismatches++;
        end
      end
    end
    mean_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (mean_if.valid && mean_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned fed;
    int unsigned frame_no;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = bmf_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    pix_if.valid  = 1'b0;
    pix_if.pixel  = '0;
    mean_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        write_reg(directed_rows[k].idx, directed_rows[k].value);
      end else begin
        repeat (directed_rows[k].count)
          feed_pixel(directed_rows[k].pixel, directed_rows[k].typed, directed_rows[k].beat);
      end
    end

    // Random small frames; idling phase rotates per frame, with a no-idle
    // stretch every fourth frame.
    fed = 0;
    frame_no = 0;
    while (fed < RANDOM_ITEMS) begin
      set_idling(frame_no % 4);
      write_reg(bmf_pkg::CFG_IMAGE_WIDTH, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12));
      write_reg(bmf_pkg::CFG_IMAGE_HEIGHT, $urandom_range(0, 6));
      write_reg(bmf_pkg::CFG_WINDOW_RADIUS, $urandom_range(0, 3));
      stream_frame(frame_no % 5 == 2, fed);
      frame_no++;
    end

    drain(SETTLE_CYC);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* box_mean_filter_core.f */
+incdir+hw/rtl
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_pixel_if.sv
hw/rtl/bmf_mean_if.sv
hw/rtl/bmf_front.sv
hw/rtl/bmf_fifo.sv
hw/rtl/bmf_back.sv
hw/rtl/box_mean_filter_core.sv
hw/rtl/bmf_checker.sv
sim/box_mean_filter_core_tb.sv
